// File: src/double_ended_queue_top_defines.svh
// assertion macros for the double-ended queue checker
// no dependencies; included by the checker file only
`ifndef DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_TOP_DEFINES_SVH

// same-cycle implication, disabled while dis is high
`define DEQ_ASSERT_SAME(name, clk, dis, ante, cons) \
  name: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error("deque check failed");

// next-cycle implication, disabled while dis is high
`define DEQ_ASSERT_NEXT(name, clk, dis, ante, cons) \
  name: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error("deque check failed");

`endif

// File: src/deq_pkg.sv
// shared types and codes for the double-ended queue
// no dependencies; used by every module of the block
package deq_pkg;

  localparam int DataW  = 32;
  localparam int OpW    = 3;
  localparam int StatW  = 2;
  localparam int CountW = 5;

  // operation codes
  localparam logic [OpW-1:0] OP_DUMP       = 3'd0;
  localparam logic [OpW-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OpW-1:0] OP_PUSH_BACK  = 3'd2;
  localparam logic [OpW-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OpW-1:0] OP_POP_BACK   = 3'd4;

  // status codes
  localparam logic [StatW-1:0] ST_OK    = 2'd0;
  localparam logic [StatW-1:0] ST_EMPTY = 2'd1;
  localparam logic [StatW-1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [OpW-1:0]          op;
    logic signed [DataW-1:0] value;
  } deq_cmd_t;

  typedef struct packed {
    logic signed [DataW-1:0] value_res;
    logic [StatW-1:0]        status;
    logic [CountW-1:0]       count;
    logic                    last;
  } deq_res_t;

endpackage

// File: src/deq_ram.sv
// ring store of the double-ended queue: one write and one read port
// depends on deq_pkg for the data width; read data registered
module deq_ram import deq_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [AW-1:0]           waddr,
  input  logic signed [DataW-1:0] wdata,
  input  logic                    re,
  input  logic [AW-1:0]           raddr,
  output logic signed [DataW-1:0] rdata
);

  logic signed [DataW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/double_ended_queue_top.sv
// double-ended queue of signed 32-bit words held in a ring memory
// depends on deq_pkg and deq_ram
//
// Usage: a command word (op, value) is taken at a clock edge where start is
// high and busy is low. Results come out on res, one word per cycle while
// res_valid is high; the receiver has no way to stall them.
// Push: result strobed the cycle after the command; busy stays low, so a
// new command may follow every cycle.
// Pop: the ring memory is read once (registered read port); the result
// strobe is registered after the read data returns, and busy is high for one cycle.
// Dump: one memory read per cycle for each held element, front to back;
// results are strobed on back-to-back cycles, each registered after its read
// returns, the final one flagged last. Busy stays high until the last read
// returns. An empty pop or dump, or a refused push, answers the cycle after
// the command. Unknown op codes are taken and give no result.
// Reset clears head and count at once; no clearing pass of the memory.
module double_ended_queue_top import deq_pkg::*; #(
  parameter int DEPTH = 16
) (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  deq_cmd_t cmd,
  output logic     busy,
  output logic     res_valid,
  output deq_res_t res
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_DUMP = 1'b1;

  logic          state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] dump_k, dump_k_next;
  logic          rd_pend, rd_pend_next;
  logic          rd_last, rd_last_next;

  logic                    accept;
  logic                    is_full, is_empty;
  logic [CW-1:0]           off;
  logic [SW-1:0]           sum, wrapped;
  logic [AW-1:0]           addr_off, head_inc, head_dec;
  logic                    we, re;
  logic [AW-1:0]           waddr;
  logic signed [DataW-1:0] rdata;
  logic                    imm_valid;
  logic [StatW-1:0]        imm_status;

  assign busy     = (state == S_DUMP) || rd_pend;
  assign accept   = start && !busy;
  assign is_full  = (cnt == CW'(DEPTH));
  assign is_empty = (cnt == '0);

  // offset from head for the shared ring address adder
  always_comb begin
    off = '0;
    if (state == S_DUMP) begin
      off = dump_k;
    end else begin
      case (cmd.op)
        OP_PUSH_BACK: off = cnt;
        OP_POP_BACK:  off = cnt - CW'(1);
        default:      off = '0;
      endcase
    end
  end

  // head plus offset, modulo depth
  assign sum      = SW'(head) + SW'(off);
  assign wrapped  = (sum >= SW'(DEPTH)) ? (sum - SW'(DEPTH)) : sum;
  assign addr_off = AW'(wrapped);
  assign head_inc = (head == AW'(DEPTH - 1)) ? '0 : (head + AW'(1));
  assign head_dec = (head == '0) ? AW'(DEPTH - 1) : (head - AW'(1));

  // command sequencer
  always_comb begin
    state_next   = state;
    head_next    = head;
    cnt_next     = cnt;
    dump_k_next  = dump_k;
    rd_pend_next = 1'b0;
    rd_last_next = 1'b0;
    we           = 1'b0;
    waddr        = addr_off;
    re           = 1'b0;
    imm_valid    = 1'b0;
    imm_status   = ST_OK;
    if (state == S_DUMP) begin
      re           = 1'b1;
      rd_pend_next = 1'b1;
      rd_last_next = (dump_k == cnt - CW'(1));
      dump_k_next  = dump_k + CW'(1);
      if (dump_k == cnt - CW'(1)) begin
        state_next = S_IDLE;
      end
    end else if (accept) begin
      unique case (cmd.op)
        OP_DUMP: begin
          if (is_empty) begin
            imm_valid  = 1'b1;
            imm_status = ST_EMPTY;
          end else begin
            re           = 1'b1;
            rd_pend_next = 1'b1;
            rd_last_next = (cnt == CW'(1));
            dump_k_next  = CW'(1);
            if (cnt != CW'(1)) begin
              state_next = S_DUMP;
            end
          end
        end
        OP_PUSH_FRONT: begin
          imm_valid = 1'b1;
          if (is_full) begin
            imm_status = ST_FULL;
          end else begin
            we        = 1'b1;
            waddr     = head_dec;
            head_next = head_dec;
            cnt_next  = cnt + CW'(1);
          end
        end
        OP_PUSH_BACK: begin
          imm_valid = 1'b1;
          if (is_full) begin
            imm_status = ST_FULL;
          end else begin
            we       = 1'b1;
            cnt_next = cnt + CW'(1);
          end
        end
        OP_POP_FRONT: begin
          if (is_empty) begin
            imm_valid  = 1'b1;
            imm_status = ST_EMPTY;
          end else begin
            re           = 1'b1;
            rd_pend_next = 1'b1;
            rd_last_next = 1'b1;
            head_next    = head_inc;
            cnt_next     = cnt - CW'(1);
          end
        end
        OP_POP_BACK: begin
          if (is_empty) begin
            imm_valid  = 1'b1;
            imm_status = ST_EMPTY;
          end else begin
            re           = 1'b1;
            rd_pend_next = 1'b1;
            rd_last_next = 1'b1;
            cnt_next     = cnt - CW'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      head    <= '0;
      cnt     <= '0;
      dump_k  <= '0;
      rd_pend <= 1'b0;
      rd_last <= 1'b0;
    end else begin
      state   <= state_next;
      head    <= head_next;
      cnt     <= cnt_next;
      dump_k  <= dump_k_next;
      rd_pend <= rd_pend_next;
      rd_last <= rd_last_next;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else begin
      res_valid <= rd_pend || imm_valid;
    end
  end

  // result word: memory data when a read returns, else a status-only word
  always_ff @(posedge clk) begin
    if (rd_pend) begin
      res.value_res <= rdata;
      res.status    <= ST_OK;
      res.count     <= CountW'(cnt);
      res.last      <= rd_last;
    end else begin
      res.value_res <= '0;
      res.status    <= imm_status;
      res.count     <= CountW'(cnt_next);
      res.last      <= 1'b1;
    end
  end

  deq_ram #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(cmd.value),
    .re   (re),
    .raddr(addr_off),
    .rdata(rdata)
  );

endmodule

// File: src/deq_chk.sv
// port-level checker for the double-ended queue, bound to the top level
// depends on deq_pkg and double_ended_queue_top_defines.svh
`include "double_ended_queue_top_defines.svh"

module deq_chk import deq_pkg::*; (
  input logic     clk,
  input logic     rst,
  input logic     start,
  input logic     busy,
  input deq_cmd_t cmd,
  input logic     res_valid,
  input deq_res_t res
);

  logic push_acc;

  assign push_acc = start && !busy &&
                    (cmd.op == OP_PUSH_FRONT || cmd.op == OP_PUSH_BACK);

  // reset leaves no word on the result port
  `DEQ_ASSERT_NEXT(a_rst_quiet, clk, 1'b0, rst, !res_valid)

  // a push answers on the next cycle with a single status word
  `DEQ_ASSERT_NEXT(a_push_answer, clk, rst, push_acc,
    res_valid && res.last && res.value_res == '0)

  // words of one dump come back to back until the last
  `DEQ_ASSERT_NEXT(a_dump_burst, clk, rst, res_valid && !res.last, res_valid)

  // an empty answer reports an empty store
  `DEQ_ASSERT_SAME(a_empty_count, clk, rst, res_valid && res.status == ST_EMPTY,
    res.count == '0 && res.last)

endmodule

bind double_ended_queue_top deq_chk u_chk (.*);
